[rtl/tdsf_pkg.sv]
// ----------------------------------------------------------------------------
// tdsf_pkg
// shared widths, register indexes and item types of the decay start finder
// ----------------------------------------------------------------------------
package tdsf_pkg;

   localparam int SAMPLE_BITS  = 24;
   localparam int RECORD_DEPTH = 1024;
   localparam int BL_W         = 11;
   localparam int FRAC_W       = 16;
   localparam int IDX_W        = 11;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LEN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRACTION = 1'b1;

   localparam logic [BL_W-1:0]   BASE_LEN_RESET = 11'd1;
   localparam logic [FRAC_W-1:0] FRACTION_RESET = 16'd32768;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } req_item_type;

   typedef struct packed {
      logic [IDX_W-1:0] start_index;
      logic             too_short;
   } rsp_item_type;

endpackage

[rtl/tdsf_ram.sv]
// ----------------------------------------------------------------------------
// tdsf_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module tdsf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tdsf_div.sv]
// ----------------------------------------------------------------------------
// tdsf_div
// signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero
// ----------------------------------------------------------------------------
module tdsf_div #(
   parameter int NUM_W = 35,
   parameter int DEN_W = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0]        divisor,
   output logic                    done,
   output logic signed [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         neg_in  = dividend[NUM_W-1];
         quo_in  = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

[rtl/transient_decay_start_finder.sv]
// ----------------------------------------------------------------------------
// transient_decay_start_finder
// loads a record of samples, then reports the first index after the peak
// that falls to or below baseline + fraction * (peak - baseline)
// ----------------------------------------------------------------------------
// usage
//   req channel: one sample per item, last marks the end of the record.
//   samples load at one item per cycle into the sample ram; the running
//   baseline sum and the peak are kept in registers.
//   after the last item req_stall rises while the record is evaluated:
//   the baseline divide runs one quotient bit per cycle over the 35 bit
//   sum, the diff, product and thresh states form the threshold, the scan
//   reads one ram entry per cycle from the entry after the peak on, each
//   entry compared after its registered read, and the reply state loads
//   the rsp register.
//   rsp channel: one item per record. the rsp item sits in an output register;
//   a stall on rsp holds it there and blocks only a following record's end.
//   csr channel: always ready; write only while no record is being evaluated.
//   reset clears the record state and the registers to base length 1 and
//   fraction 32768; the ram is not cleared, since only entries of the
//   current record are read.
// ----------------------------------------------------------------------------
module transient_decay_start_finder #(
   parameter int RECORD_DEPTH = tdsf_pkg::RECORD_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tdsf_pkg::req_item_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tdsf_pkg::rsp_item_type            rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tdsf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tdsf_pkg::CSR_DATA_W-1:0]   csr_data
);

   import tdsf_pkg::*;

   localparam int ADDR_W = $clog2(RECORD_DEPTH);
   localparam int CNT_W  = $clog2(RECORD_DEPTH + 1);
   localparam int SUM_W  = SAMPLE_BITS + ADDR_W + 1;
   localparam int CMP_W  = (CNT_W > BL_W) ? CNT_W : BL_W;
   localparam int DIFF_W = SAMPLE_BITS + 1;
   localparam int THR_W  = SAMPLE_BITS + FRAC_W + 2;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DIVIDE,
      ST_DIFF,
      ST_PRODUCT,
      ST_THRESH,
      ST_SCAN,
      ST_REPLY
   } state_type;

   state_type                   state_ff, state_in;
   logic [BL_W-1:0]             bl_ff, bl_in;
   logic [FRAC_W-1:0]           frac_ff, frac_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic [ADDR_W-1:0]           pidx_ff, pidx_in;
   logic signed [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic signed [DIFF_W-1:0]    diff_ff, diff_in;
   logic signed [THR_W-1:0]     prod_ff, prod_in;
   logic signed [THR_W-1:0]     thr_ff, thr_in;
   logic                        short_ff, short_in;
   logic [CNT_W-1:0]            scan_idx_ff, scan_idx_in;
   logic                        cmp_valid_ff, cmp_valid_in;
   logic [CNT_W-1:0]            cmp_idx_ff, cmp_idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_item_type                rsp_data_ff, rsp_data_in;

   logic [BL_W-1:0]             bl_eff;
   logic signed [SAMPLE_BITS-1:0] smp;
   logic                        mem_wr_en;
   logic                        mem_rd_en;
   logic [SAMPLE_BITS-1:0]      mem_rd_data;
   logic                        div_start;
   logic                        div_done;
   logic signed [SUM_W-1:0]     div_quo;
   logic signed [THR_W-1:0]     smp_q16;
   logic                        above;

   assign bl_eff  = (bl_ff == '0) ? BL_W'(1) : bl_ff;
   assign smp     = $signed(req_data.sample);
   assign smp_q16 = THR_W'($signed({mem_rd_data, FRAC_W'(0)}));
   assign above   = smp_q16 > thr_ff;

   tdsf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RECORD_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_data.sample),
      .rd_en   (mem_rd_en),
      .rd_addr (scan_idx_ff[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   tdsf_div #(
      .NUM_W (SUM_W),
      .DEN_W (BL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (bl_eff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      bl_in        = bl_ff;
      frac_in      = frac_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      peak_in      = peak_ff;
      pidx_in      = pidx_ff;
      mean_in      = mean_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      thr_in       = thr_ff;
      short_in     = short_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      div_start    = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            CSR_BASE_LEN: bl_in   = csr_data[BL_W-1:0];
            CSR_FRACTION: frac_in = csr_data[FRAC_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (count_ff < CNT_W'(RECORD_DEPTH)) begin
                  mem_wr_en = 1'b1;
                  if (CMP_W'(count_ff) < CMP_W'(bl_eff)) begin
                     sum_in = sum_ff + SUM_W'(smp);
                  end
                  if (smp > peak_ff) begin
                     peak_in = smp;
                     pidx_in = count_ff[ADDR_W-1:0];
                  end
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_data.last) begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               mean_in  = $signed(div_quo[SAMPLE_BITS-1:0]);
               short_in = CMP_W'(count_ff) < CMP_W'(bl_eff);
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            diff_in  = DIFF_W'(peak_ff) - DIFF_W'(mean_ff);
            state_in = ST_PRODUCT;
         end
         ST_PRODUCT: begin
            prod_in  = THR_W'($signed({1'b0, frac_ff})) * THR_W'(diff_ff);
            state_in = ST_THRESH;
         end
         ST_THRESH: begin
            thr_in      = (THR_W'(mean_ff) <<< FRAC_W) + prod_ff;
            scan_idx_in = CNT_W'(pidx_ff) + CNT_W'(1);
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (cmp_valid_ff && !above) begin
               state_in = ST_REPLY;
            end else if (scan_idx_ff < count_ff) begin
               mem_rd_en    = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_idx_ff;
               scan_idx_in  = scan_idx_ff + CNT_W'(1);
            end else begin
               cmp_idx_in = count_ff;
               state_in   = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.start_index = IDX_W'(cmp_idx_ff);
               rsp_data_in.too_short   = short_ff;
               count_in                = '0;
               sum_in                  = '0;
               peak_in                 = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
               pidx_in                 = '0;
               state_in                = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         bl_ff        <= BASE_LEN_RESET;
         frac_ff      <= FRACTION_RESET;
         count_ff     <= '0;
         sum_ff       <= '0;
         peak_ff      <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         pidx_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bl_ff        <= bl_in;
         frac_ff      <= frac_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         peak_ff      <= peak_in;
         pidx_ff      <= pidx_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mean_ff     <= mean_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      thr_ff      <= thr_in;
      short_ff    <= short_in;
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule
